// ===== hdl/shortest_queue_dispatcher_top_macros.svh =====
// Assertion macros shared by the dispatcher RTL.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef SHORTEST_QUEUE_DISPATCHER_TOP_MACROS_SVH
`define SHORTEST_QUEUE_DISPATCHER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define SQD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SQD_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define SQD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/sqd_pkg.sv =====
package sqd_pkg;

    localparam int NUM_COUNTERS = 3;
    localparam int QUEUE_DEPTH  = 16;

    localparam int TAG_W    = 32;
    localparam int CNT_W    = 3;
    localparam int STATUS_W = 3;
    localparam int QIDX_W   = 3;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QSEL_W  = $clog2(NUM_COUNTERS);
    localparam int ENTRIES = NUM_COUNTERS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_JOINED  = 3'd0,
        ST_SERVED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  wdata;
    } t_ram_req;

endpackage

// ===== hdl/sqd_ram.sv =====
module sqd_ram
    import sqd_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_req         i_req,
    output logic [TAG_W-1:0] o_rdata
);

    logic [TAG_W-1:0] r_mem [ENTRIES];
    logic [TAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/shortest_queue_dispatcher_top.sv =====
// Channel   Handshake             Payload
// request   start, busy           i_mode, i_tag, i_counter
// result    o_valid (strobe)      o_status, o_queue_index, o_tag_out
//
// A request is taken when start is high and busy is low; one may follow every cycle.
// The transfer edge loads the input register. The queue decision and the tag store access
// use the next cycle, and the result register and the registered read port load at its end,
// which puts the result on the ports.
// busy is high only during reset and in the first cycle after it.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`include "shortest_queue_dispatcher_top_macros.svh"

module shortest_queue_dispatcher_top
    import sqd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_mode,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic [CNT_W-1:0]    i_counter,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [QIDX_W-1:0]   o_queue_index,
    output logic [TAG_W-1:0]    o_tag_out
);

    logic r_init;

    // Input register.
    logic             r_s1_valid;
    logic             r_s1_mode;
    logic [TAG_W-1:0] r_s1_tag;
    logic [CNT_W-1:0] r_s1_counter;

    // Queue pointers and fill levels.
    logic [PTR_W-1:0] r_head [NUM_COUNTERS];
    logic [PTR_W-1:0] r_tail [NUM_COUNTERS];
    logic [OCC_W-1:0] r_occ  [NUM_COUNTERS];

    // Result register.
    logic              r_s2_valid;
    t_status           r_s2_status;
    logic [QIDX_W-1:0] r_s2_qidx;
    logic [TAG_W-1:0]  r_s2_tag;
    logic              r_s2_use_ram;

    logic              accept;
    logic [QSEL_W-1:0] best;
    logic [QSEL_W-1:0] q_sel;
    logic              cnt_ok;
    logic              all_full;
    logic [OCC_W-1:0]  occ_sel;
    logic [PTR_W-1:0]  ptr_sel;
    logic [PTR_W-1:0]  ptr_next;
    logic              do_join;
    logic              do_serve;
    t_status           n_status;
    logic [QIDX_W-1:0] n_qidx;
    logic [TAG_W-1:0]  n_tag;
    t_ram_req          ram_req;
    logic [TAG_W-1:0]  ram_rdata;

    assign busy   = ~r_init | ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_init     <= 1'b1;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode    <= i_mode;
            r_s1_tag     <= i_tag;
            r_s1_counter <= i_counter;
        end
    end

    // Shortest queue; a strict compare keeps ties on the lowest number.
    always_comb begin
        best     = '0;
        all_full = 1'b1;
        for (int i = 1; i < NUM_COUNTERS; i++) begin
            if (r_occ[i] < r_occ[best]) begin
                best = QSEL_W'(i);
            end
        end
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            if (r_occ[i] != OCC_W'(QUEUE_DEPTH)) begin
                all_full = 1'b0;
            end
        end
    end

    assign cnt_ok = (r_s1_counter != '0) && (r_s1_counter <= CNT_W'(NUM_COUNTERS));

    always_comb begin
        q_sel = (r_s1_mode == MODE_ARRIVE) ? best : QSEL_W'(r_s1_counter - CNT_W'(1));
    end

    assign occ_sel  = r_occ[q_sel];
    assign ptr_sel  = (r_s1_mode == MODE_ARRIVE) ? r_tail[q_sel] : r_head[q_sel];
    assign ptr_next = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + PTR_W'(1);

    always_comb begin
        do_join  = 1'b0;
        do_serve = 1'b0;
        n_tag    = '0;
        n_qidx   = QIDX_W'(q_sel) + QIDX_W'(1);
        n_status = ST_INVALID;
        if (r_s1_mode == MODE_ARRIVE) begin
            if (occ_sel == OCC_W'(QUEUE_DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_JOINED;
                n_tag    = r_s1_tag;
                do_join  = r_s1_valid;
            end
        end else if (!cnt_ok) begin
            n_status = ST_INVALID;
            n_qidx   = '0;
        end else if (occ_sel == '0) begin
            n_status = ST_EMPTY;
        end else begin
            n_status = ST_SERVED;
            do_serve = r_s1_valid;
        end
    end

    always_comb begin
        ram_req.we    = do_join;
        ram_req.re    = do_serve;
        ram_req.addr  = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);
        ram_req.wdata = r_s1_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
        end else if (do_join) begin
            r_tail[q_sel] <= ptr_next;
            r_occ[q_sel]  <= occ_sel + OCC_W'(1);
        end else if (do_serve) begin
            r_head[q_sel] <= ptr_next;
            r_occ[q_sel]  <= occ_sel - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_status  <= n_status;
        r_s2_qidx    <= n_qidx;
        r_s2_tag     <= n_tag;
        r_s2_use_ram <= do_serve;
    end

    sqd_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_valid       = r_s2_valid;
    assign o_status      = r_s2_status;
    assign o_queue_index = r_s2_qidx;
    assign o_tag_out     = r_s2_use_ram ? ram_rdata : r_s2_tag;

    // A request in the input register gives a result strobe in the next cycle.
    `SQD_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, r_s1_valid, o_valid)

    // A full result is only possible when every queue is at its limit.
    `SQD_ASSERT_SAME(a_full_means_all, i_clk, i_rst_n,
        r_s1_valid && r_s1_mode == MODE_ARRIVE && n_status == ST_FULL, all_full)

    // Only an invalid serve reports queue number zero.
    `SQD_ASSERT_SAME(a_qidx_nonzero, i_clk, i_rst_n,
        o_valid && o_status != ST_INVALID, o_queue_index != '0)

    // A served or joined result always moves exactly one fill level by one.
    `SQD_ASSERT_NEXT(a_occ_moves, i_clk, i_rst_n, do_join || do_serve,
        r_occ[$past(q_sel)] != $past(occ_sel))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sqd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        t_status             status;
        logic [QIDX_W-1:0]   queue_index;
        logic [TAG_W-1:0]    tag_out;
    } dispatch_result_t;

    // Tracks the contents of every queue and the results the dispatcher owes.
    class dispatch_scoreboard;
        logic [TAG_W-1:0] held_tags[NUM_COUNTERS][$];
        dispatch_result_t expected_results[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Works out the outcome of one accepted request and updates the queues.
        function void note_request(logic mode, logic [TAG_W-1:0] tag,
                                   logic [CNT_W-1:0] counter);
            dispatch_result_t outcome;
            int               best;
            outcome.status      = ST_INVALID;
            outcome.queue_index = '0;
            outcome.tag_out     = '0;
            if (mode == MODE_ARRIVE) begin
                best = 0;
                for (int i = 1; i < NUM_COUNTERS; i++) begin
                    if (held_tags[i].size() < held_tags[best].size()) begin
                        best = i;
                    end
                end
                outcome.queue_index = QIDX_W'(best + 1);
                if (held_tags[best].size() >= QUEUE_DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    held_tags[best].push_back(tag);
                    outcome.status  = ST_JOINED;
                    outcome.tag_out = tag;
                end
            end else if (counter >= 1 && counter <= NUM_COUNTERS) begin
                outcome.queue_index = QIDX_W'(counter);
                if (held_tags[counter - 1].size() == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    outcome.status  = ST_SERVED;
                    outcome.tag_out = held_tags[counter - 1].pop_front();
                end
            end
            expected_results.push_back(outcome);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [QIDX_W-1:0] queue_index,
                                   logic [TAG_W-1:0] tag_out);
            dispatch_result_t want;
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: status %0d queue_index %0d tag_out %h",
                       status, queue_index, tag_out);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (queue_index !== want.queue_index) begin
                $error("queue_index: expected %0d, actual %0d", want.queue_index, queue_index);
                mismatches++;
            end
            if (tag_out !== want.tag_out) begin
                $error("tag_out: expected %h, actual %h", want.tag_out, tag_out);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_mode;
    logic [TAG_W-1:0]    i_tag;
    logic [CNT_W-1:0]    i_counter;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [QIDX_W-1:0]   o_queue_index;
    logic [TAG_W-1:0]    o_tag_out;

    dispatch_scoreboard sb = new();
    int unsigned        stall_cycles = 0;

    shortest_queue_dispatcher_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_tag         (i_tag),
        .i_counter     (i_counter),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_queue_index (o_queue_index),
        .o_tag_out     (o_tag_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_status, o_queue_index, o_tag_out);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Each call starts and ends at a rising edge; the transfer is noted at the edge
    // where start was high and busy was low.
    task automatic send_request(input logic mode, input logic [TAG_W-1:0] tag,
                                input logic [CNT_W-1:0] counter, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_mode    <= mode;
        i_tag     <= tag;
        i_counter <= counter;
        do @(posedge i_clk); while (busy);
        sb.note_request(mode, tag, counter);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int arrive_pct, input int idle_pct);
        logic [CNT_W-1:0] counter;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < arrive_pct) begin
                send_request(MODE_ARRIVE, $urandom(), CNT_W'($urandom_range(7)), idle_pct);
            end else begin
                // Roughly one serve in eight names a queue that does not exist.
                if ($urandom_range(99) < 12) begin
                    if ($urandom_range(4) == 0) begin
                        counter = '0;
                    end else begin
                        counter = CNT_W'($urandom_range(7, NUM_COUNTERS + 1));
                    end
                end else begin
                    counter = CNT_W'($urandom_range(NUM_COUNTERS, 1));
                end
                send_request(MODE_SERVE, $urandom(), counter, idle_pct);
            end
        end
    endtask

    initial begin
        start     <= 1'b0;
        i_mode    <= MODE_ARRIVE;
        i_tag     <= '0;
        i_counter <= '0;
        i_rst_n   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Serves of empty queues and of every invalid queue number.
        send_request(MODE_SERVE, 32'hFFFF_FFFF, 3'd1, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd2, 0);
        send_request(MODE_SERVE, 32'h1234_5678, 3'd3, 0);
        send_request(MODE_SERVE, 32'hFFFF_FFFF, 3'd0, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd4, 0);
        send_request(MODE_SERVE, 32'hDEAD_BEEF, 3'd5, 0);
        send_request(MODE_SERVE, 32'h0000_0001, 3'd6, 0);
        send_request(MODE_SERVE, 32'h8000_0000, 3'd7, 0);
        // Arrivals spread over the queues in turn; ties go to the lowest queue.
        send_request(MODE_ARRIVE, 32'h0000_0000, 3'd0, 0);
        send_request(MODE_ARRIVE, 32'hFFFF_FFFF, 3'd7, 0);
        send_request(MODE_ARRIVE, 32'hA5A5_A5A5, 3'd2, 0);
        send_request(MODE_ARRIVE, 32'h5A5A_5A5A, 3'd5, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd2, 0);
        send_request(MODE_ARRIVE, 32'h8000_0001, 3'd1, 0);
        send_request(MODE_SERVE, 32'hFFFF_FFFF, 3'd1, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd1, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd3, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd2, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd1, 0);
        send_request(MODE_SERVE, 32'h0000_0000, 3'd3, 0);
        drain_results();

        // Fill-heavy phases drive every queue to full; serve-heavy ones drain them.
        run_random(60, 60, 0);
        drain_results();
        run_random(80, 90, 45);
        drain_results();
        run_random(80, 25, 29);
        drain_results();
        run_random(70, 85, 0);
        drain_results();
        run_random(80, 35, 45);
        drain_results();
        run_random(80, 50, 29);
        drain_results();

        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== shortest_queue_dispatcher_top.f =====
+incdir+hdl
hdl/sqd_pkg.sv
hdl/sqd_ram.sv
hdl/shortest_queue_dispatcher_top.sv
tb/testbench.sv
